### design/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and codes for the set-associative LRU cache lookup.
// ----------------------------------------------------------------------------
package sacl_pkg;

    localparam int ADDR_W = 24;
    localparam int CFG_W  = 4;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [IDX_W-1:0] REG_SET_BITS    = 2'd1;
    localparam logic [IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

    localparam logic [1:0] CODE_MISS_FILL = 2'd0;
    localparam logic [1:0] CODE_HIT_NEW   = 2'd1;
    localparam logic [1:0] CODE_HIT_REORD = 2'd2;

    typedef struct packed {
        logic [23:0] address;
        logic        action;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [2:0]  way;
        logic [1:0]  order_code;
        logic [23:0] tag_out;
        logic [7:0]  set_out;
        logic [11:0] offset_out;
        logic [31:0] read_hit_total;
        logic [31:0] read_miss_total;
        logic [31:0] write_hit_total;
        logic [31:0] write_miss_total;
    } rsp_t;

    // Decoded reference passed from front to back.
    typedef struct packed {
        logic [31:0] tag;
        logic [7:0]  set_out;
        logic [11:0] offset;
        logic [11:0] set_idx;
        logic        action;
    } cmd_t;

endpackage

### design/sacl_front.sv
// ----------------------------------------------------------------------------
// sacl_front
// Accept references, split the address into tag, set and offset fields and
// hold the decoded beat in a one-entry queue for the back end.
// ----------------------------------------------------------------------------
module sacl_front #(
    parameter int ADDR_BITS = 24,
    parameter int SET_W     = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sacl_pkg::req_t    req,
    input  logic [3:0]        offset_bits,
    input  logic [3:0]        set_bits,
    output logic              busy,
    output logic              q_valid,
    output sacl_pkg::cmd_t    q_cmd,
    input  logic              q_pop
);
    import sacl_pkg::*;

    logic        q_valid_reg, q_valid_next;
    cmd_t        q_cmd_reg;
    cmd_t        dec;
    logic [31:0] addr;
    logic [31:0] setx;
    logic [4:0]  tshift;

    // Decode the address
    always_comb
    begin
        addr         = 32'(req.address) & 32'((33'd1 << ADDR_BITS) - 33'd1);
        tshift       = 5'(offset_bits) + 5'(set_bits);
        setx         = (addr >> offset_bits) & ((32'd1 << set_bits) - 32'd1);
        dec.offset   = 12'(addr & ((32'd1 << offset_bits) - 32'd1));
        dec.set_out  = setx[7:0];
        dec.set_idx  = 12'(setx[SET_W-1:0]);
        dec.tag      = addr >> tshift;
        dec.action   = req.action;
    end

    // One-entry queue
    always_comb
    begin
        q_valid_next = q_valid_reg;
        if (q_pop)
        begin
            q_valid_next = 1'b0;
        end
        if (start && !busy)
        begin
            q_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
        end
        else
        begin
            q_valid_reg <= q_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            q_cmd_reg <= dec;
        end
    end

    assign q_valid = q_valid_reg;
    assign q_cmd   = q_cmd_reg;
    assign busy    = q_valid_reg;
endmodule

### design/sacl_back.sv
// ----------------------------------------------------------------------------
// sacl_back
// After reset clear every set; then read the set's line, compare tags, choose the
// LRU victim on a miss, write back the line and update the hit and miss counters.
// ----------------------------------------------------------------------------
module sacl_back #(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  sacl_pkg::cmd_t    q_cmd,
    output logic              q_pop,
    input  logic [3:0]        ways_in_use,
    output logic              done,
    output sacl_pkg::rsp_t    rsp,
    output logic              back_busy
);
    import sacl_pkg::*;

    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SW    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

    typedef struct packed {
        logic [MAX_WAYS-1:0]           valid;
        logic [MAX_WAYS-1:0][23:0]     tags;
        logic [MAX_WAYS-1:0][3:0]      ages;
    } line_t;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_WRITE} state_t;

    line_t       mem [MAX_SETS];
    line_t       rd_reg;
    line_t       wr_line;
    state_t      state_reg;
    logic [SW:0] clr_reg;
    cmd_t        cmd_reg;
    logic [31:0] rh_reg, rm_reg, wh_reg, wm_reg;
    logic        done_reg;
    rsp_t        rsp_reg;
    logic [3:0]  n;
    logic        hit;
    logic [WAY_W-1:0] hw, mw, vw;
    logic        found_max;
    logic [3:0]  best, a;
    logic [1:0]  code;
    logic [SW-1:0] sidx;

    assign sidx = cmd_reg.set_idx[SW-1:0];

    // Effective way count
    always_comb
    begin
        if (ways_in_use == 4'd0)
            n = 4'd1;
        else if (32'(ways_in_use) > MAX_WAYS)
            n = 4'(MAX_WAYS);
        else
            n = ways_in_use;
    end

    // Lookup and LRU update on the registered line
    always_comb
    begin
        hit = 1'b0;
        hw = '0;
        mw = '0;
        found_max = 1'b0;
        best = 4'd0;
        vw = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (32'(w) < 32'(n) && rd_reg.valid[w] && 32'(rd_reg.tags[w]) == cmd_reg.tag)
            begin
                hit = 1'b1;
                hw  = WAY_W'(w);
            end
            if (32'(w) < 32'(n) && rd_reg.ages[w] == n - 4'd1)
            begin
                found_max = 1'b1;
                mw = WAY_W'(w);
            end
        end
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (32'(w) < 32'(n) && (w == 0 || rd_reg.ages[w] > best))
            begin
                best = rd_reg.ages[w];
                vw   = WAY_W'(w);
            end
        end
        if (!hit)
            hw = found_max ? mw : vw;
        a = rd_reg.ages[hw];
        wr_line = rd_reg;
        if (hit && a == 4'd0)
            code = CODE_HIT_NEW;
        else
        begin
            code = hit ? CODE_HIT_REORD : CODE_MISS_FILL;
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                if (32'(w) < 32'(n) && WAY_W'(w) != hw && rd_reg.ages[w] < a)
                    wr_line.ages[w] = rd_reg.ages[w] + 4'd1;
            end
            wr_line.ages[hw] = 4'd0;
        end
        if (!hit)
        begin
            wr_line.tags[hw]  = cmd_reg.tag[23:0];
            wr_line.valid[hw] = 1'b1;
        end
    end

    // Line memory: clearing pass, read, write back
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                mem[clr_reg[SW-1:0]].valid[w] <= 1'b0;
                mem[clr_reg[SW-1:0]].tags[w]  <= '0;
                mem[clr_reg[SW-1:0]].ages[w]  <= n - 4'd1;
            end
        end
        else if (state_reg == S_WRITE)
        begin
            mem[sidx] <= wr_line;
        end
        rd_reg <= mem[sidx];
    end

    // Sequencer, counters and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            rh_reg    <= '0;
            rm_reg    <= '0;
            wh_reg    <= '0;
            wm_reg    <= '0;
            done_reg  <= 1'b0;
            rsp_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == MAX_SETS - 1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (q_valid)
                        state_reg <= S_READ;
                end
                S_READ:
                begin
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    rsp_reg.hit        <= hit;
                    rsp_reg.way        <= 3'(hw);
                    rsp_reg.order_code <= code;
                    rsp_reg.tag_out    <= cmd_reg.tag[23:0];
                    rsp_reg.set_out    <= cmd_reg.set_out;
                    rsp_reg.offset_out <= cmd_reg.offset;
                    rsp_reg.read_hit_total   <= rh_reg + 32'(hit && !cmd_reg.action);
                    rsp_reg.read_miss_total  <= rm_reg + 32'(!hit && !cmd_reg.action);
                    rsp_reg.write_hit_total  <= wh_reg + 32'(hit && cmd_reg.action);
                    rsp_reg.write_miss_total <= wm_reg + 32'(!hit && cmd_reg.action);
                    rh_reg <= rh_reg + 32'(hit && !cmd_reg.action);
                    rm_reg <= rm_reg + 32'(!hit && !cmd_reg.action);
                    wh_reg <= wh_reg + 32'(hit && cmd_reg.action);
                    wm_reg <= wm_reg + 32'(!hit && cmd_reg.action);
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Latch the command on pop
    always_ff @(posedge clk)
    begin
        if (q_pop)
            cmd_reg <= q_cmd;
    end

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign back_busy = (state_reg == S_CLEAR);
endmodule

### design/set_assoc_cache_lru_lookup.sv
// Flow: an accepted reference waits in the one-entry queue, is popped into the
// command register, its set's line is read and then written back; done rises
// with the write back. References are served one at a time, each by that read
// and write back in a single-port line memory; the queue can hold another
// reference meanwhile. Reset: configuration returns to 4/6/4; a clearing pass
// over all MAX_SETS sets then runs with busy high. Results are strobed on done and cannot be stalled.
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup
// Set-associative cache tag lookup with true LRU replacement and counters.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup #(
    parameter int ADDR_BITS = 24,
    parameter int MAX_SETS  = 256,
    parameter int MAX_WAYS  = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  sacl_pkg::req_t      req,
    output logic                busy,
    output logic                done,
    output sacl_pkg::rsp_t      rsp,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [3:0]          cfg_data
);
    import sacl_pkg::*;

    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

    logic [3:0] offset_bits_reg, set_bits_reg, ways_reg;
    logic       q_valid, q_pop, front_busy, back_busy;
    cmd_t       q_cmd;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= 4'd4;
            set_bits_reg    <= 4'd6;
            ways_reg        <= 4'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                REG_SET_BITS:    set_bits_reg    <= cfg_data;
                REG_WAYS_IN_USE: ways_reg        <= cfg_data;
                default:         ;
            endcase
        end
    end

    sacl_front #(.ADDR_BITS(ADDR_BITS), .SET_W(SET_W)) u_front (
        .clk(clk), .rst_n(rst_n), .start(start && !back_busy), .req(req),
        .offset_bits(offset_bits_reg), .set_bits(set_bits_reg),
        .busy(front_busy), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
    );

    sacl_back #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
        .ways_in_use(ways_reg), .done(done), .rsp(rsp), .back_busy(back_busy)
    );

    assign busy = front_busy || back_busy;
endmodule

### tb/sv/sacl_checker.sv
// ----------------------------------------------------------------------------
// sacl_checker
// Watches the command, result and register ports of the cache lookup, keeps
// its own LRU cache state and counters, and compares every result beat.
// ----------------------------------------------------------------------------
module sacl_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  sacl_pkg::req_t   req,
    input  logic             done,
    input  sacl_pkg::rsp_t   rsp,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [3:0]       cfg_data,
    output int               errors,
    output int               pending,
    output int               hit_count,
    output int               miss_count
);
    import sacl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETS = 256;
    localparam int WAYS = 8;

    logic [3:0]  offset_bits;
    logic [3:0]  set_bits;
    logic [3:0]  ways_in_use;
    logic [23:0] tag_mem [SETS][WAYS];
    logic        line_vld [SETS][WAYS];
    logic [2:0]  line_age [SETS][WAYS];
    logic [31:0] rd_hits, rd_misses, wr_hits, wr_misses;
    rsp_t        lookup_q [$];

    assign pending = lookup_q.size();

    // Look up one reference, update the LRU state and return the result beat
    function automatic rsp_t lookup(req_t r);
        rsp_t        o;
        int          n;
        int          s;
        int          hw;
        logic        found;
        logic [2:0]  a;
        logic [63:0] a64, off, setx, tag;
        n   = (ways_in_use == 0) ? 1 : (ways_in_use > WAYS) ? WAYS : ways_in_use;
        a64 = {40'd0, r.address};
        off  = a64 & ((64'd1 << offset_bits) - 64'd1);
        setx = (a64 >> offset_bits) & ((64'd1 << set_bits) - 64'd1);
        tag  = a64 >> (5'(offset_bits) + 5'(set_bits));
        s    = int'(setx[7:0]);
        hw   = 0;
        found = 1'b0;
        for (int w = 0; w < n; w++)
        begin
            if (!found && line_vld[s][w] && {40'd0, tag_mem[s][w]} == tag)
            begin
                found = 1'b1;
                hw = w;
            end
        end
        o = '0;
        o.hit = found;
        if (found)
        begin
            a = line_age[s][hw];
            if (a == 0)
                o.order_code = CODE_HIT_NEW;
            else
            begin
                o.order_code = CODE_HIT_REORD;
                for (int w = 0; w < n; w++)
                    if (w != hw && line_age[s][w] < a) line_age[s][w]++;
                line_age[s][hw] = '0;
            end
            if (r.action) wr_hits++; else rd_hits++;
        end
        else
        begin
            // Victim: first way at the oldest age, else first with greatest age
            found = 1'b0;
            for (int w = 0; w < n; w++)
            begin
                if (!found && line_age[s][w] == 3'(n - 1))
                begin
                    found = 1'b1;
                    hw = w;
                end
            end
            if (!found)
            begin
                hw = 0;
                for (int w = 1; w < n; w++)
                    if (line_age[s][w] > line_age[s][hw]) hw = w;
            end
            a = line_age[s][hw];
            for (int w = 0; w < n; w++)
                if (w != hw && line_age[s][w] < a) line_age[s][w]++;
            line_age[s][hw] = '0;
            tag_mem[s][hw]  = tag[23:0];
            line_vld[s][hw] = 1'b1;
            o.order_code = CODE_MISS_FILL;
            if (r.action) wr_misses++; else rd_misses++;
        end
        o.way              = 3'(hw);
        o.tag_out          = tag[23:0];
        o.set_out          = setx[7:0];
        o.offset_out       = off[11:0];
        o.read_hit_total   = rd_hits;
        o.read_miss_total  = rd_misses;
        o.write_hit_total  = wr_hits;
        o.write_miss_total = wr_misses;
        return o;
    endfunction

    function automatic int check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    // Track registers, predict accepted beats, compare result beats
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t e;
        int   bad;
        if (!rst_n)
        begin
            offset_bits = 4'd4;
            set_bits    = 4'd6;
            ways_in_use = 4'd4;
            for (int s = 0; s < SETS; s++)
                for (int w = 0; w < WAYS; w++)
                begin
                    tag_mem[s][w]  = '0;
                    line_vld[s][w] = 1'b0;
                    line_age[s][w] = 3'd3;
                end
            rd_hits = '0; rd_misses = '0; wr_hits = '0; wr_misses = '0;
            lookup_q.delete();
            errors     = 0;
            hit_count  = 0;
            miss_count = 0;
        end
        else
        begin
            if (done)
            begin
                if (lookup_q.size() == 0)
                begin
                    $display("%0t ns: result beat with nothing expected, got %h", $time, rsp);
                    errors++;
                end
                else
                begin
                    e = lookup_q.pop_front();
                    bad = 0;
                    bad += check_field("hit", e.hit, rsp.hit);
                    bad += check_field("way", e.way, rsp.way);
                    bad += check_field("order_code", e.order_code, rsp.order_code);
                    bad += check_field("tag_out", e.tag_out, rsp.tag_out);
                    bad += check_field("set_out", e.set_out, rsp.set_out);
                    bad += check_field("offset_out", e.offset_out, rsp.offset_out);
                    bad += check_field("read_hit_total", e.read_hit_total,
                                       rsp.read_hit_total);
                    bad += check_field("read_miss_total", e.read_miss_total,
                                       rsp.read_miss_total);
                    bad += check_field("write_hit_total", e.write_hit_total,
                                       rsp.write_hit_total);
                    bad += check_field("write_miss_total", e.write_miss_total,
                                       rsp.write_miss_total);
                    if (bad != 0) errors++;
                    if (e.hit) hit_count++; else miss_count++;
                end
            end
            if (start && !busy)
                lookup_q.push_back(lookup(req));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OFFSET_BITS: offset_bits = cfg_data;
                    REG_SET_BITS:    set_bits    = cfg_data;
                    REG_WAYS_IN_USE: ways_in_use = cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

### tb/sv/tb_set_assoc_cache_lru_lookup.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_lru_lookup
// Drives directed references and random bursts through the cache lookup under a
// series of field and associativity settings; a checker compares every result.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_lru_lookup;
    import sacl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 5000;

    logic       clk;
    logic       rst_n;
    logic       start;
    req_t       req;
    logic       busy;
    logic       done;
    rsp_t       rsp;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [3:0] cfg_data;
    int         errors, pending, hit_count, miss_count;
    int         idle_cycles;
    int         sent;
    int         settings;
    logic [3:0] cur_ob, cur_sb, cur_ways;

    set_assoc_cache_lru_lookup i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .req(req), .busy(busy),
        .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    sacl_checker i_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .errors(errors), .pending(pending),
        .hit_count(hit_count), .miss_count(miss_count)
    );

    always
    begin
        clk = 1'b1; #1;
        clk = 1'b0; #1;
    end

    // Watchdog: end the run after too many cycles without a beat
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Hold start and the command until the block takes the beat
    task automatic issue(input logic [23:0] addr, input logic act);
        logic was_busy;
        start <= 1'b1;
        req   <= '{address: addr, action: act};
        do
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
        end
        while (was_busy);
        sent++;
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drain outstanding lookups, then let the pipeline settle
    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_OFFSET_BITS: cur_ob   = val;
            REG_SET_BITS:    cur_sb   = val;
            REG_WAYS_IN_USE: cur_ways = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [3:0] ob, input logic [3:0] sb,
                             input logic [3:0] ways);
        drain();
        write_reg(REG_OFFSET_BITS, ob);
        write_reg(REG_SET_BITS, sb);
        write_reg(REG_WAYS_IN_USE, ways);
        settings++;
    endtask

    // Build an address from a few sets and tags so lines get reused
    function automatic logic [23:0] pooled_addr();
        logic [63:0] a;
        int          ntags;
        ntags = (cur_ways == 0) ? 2 : int'(cur_ways) + 2;
        a = (64'($urandom_range(0, ntags)) << (int'(cur_ob) + int'(cur_sb)))
          | (64'($urandom_range(0, 3)) << cur_ob)
          | (64'($urandom) & ((64'd1 << cur_ob) - 64'd1));
        return a[23:0];
    endfunction

    task automatic random_phase(input int count);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    issue(24'($urandom), 1'($urandom));
                else
                    issue(pooled_addr(), 1'($urandom));
                burst--;
                left--;
            end
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        start     = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_OFFSET_BITS;
        cfg_data  = '0;
        sent      = 0;
        settings  = 1;
        idle_cycles = 0;
        cur_ob = 4'd4; cur_sb = 4'd6; cur_ways = 4'd4;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        // Wait out the clearing pass
        @(posedge clk);
        while (busy) @(posedge clk);

        // Directed: cold miss, hit on newest, extreme address, eviction, reorder
        issue(24'h000000, 1'b0);
        issue(24'h000000, 1'b1);
        issue(24'hFFFFFF, 1'b1);
        for (int t = 1; t <= 5; t++)
            issue(24'(t << 10), 1'b0);
        issue(24'h000400 | 24'h00F, 1'b1);
        issue(24'h001400, 1'b0);
        pause(3);
        issue(24'h000800, 1'b1);
        // Narrowest fields and a single way
        configure(4'd0, 4'd0, 4'd1);
        issue(24'hFFFFFF, 1'b0);
        issue(24'hFFFFFF, 1'b1);
        issue(24'h000000, 1'b0);
        // Widest documented fields and all ways
        configure(4'd12, 4'd8, 4'd8);
        issue(24'hFFFFFF, 1'b0);
        issue(24'h000FFF, 1'b1);
        issue(24'hFFFFFF, 1'b1);
        // Out-of-range ways and an oversized set index
        configure(4'd15, 4'd12, 4'd0);
        issue(24'hFFFFFF, 1'b0);
        issue(24'h7FFFFF, 1'b1);
        configure(4'd2, 4'd12, 4'd15);
        issue(24'hABCDEF, 1'b0);
        issue(24'hABCDEF, 1'b1);
        // Shrink ways without reset so no line sits at the oldest age
        configure(4'd4, 4'd6, 4'd8);
        for (int t = 0; t < 3; t++)
            issue(24'(t << 10), 1'b0);
        configure(4'd4, 4'd6, 4'd3);
        issue(24'h00F000, 1'b1);

        // Random phases under random settings, extremes in between
        random_phase(60);
        configure(4'd0, 4'd0, 4'd8);
        random_phase(50);
        configure(4'd12, 4'd8, 4'd1);
        random_phase(50);
        configure(4'd3, 4'd2, 4'd2);
        random_phase(60);
        for (int p = 0; p < 5; p++)
        begin
            configure(4'($urandom_range(0, 12)), 4'($urandom_range(0, 8)),
                      4'($urandom_range(1, 8)));
            random_phase(50);
        end
        configure(4'($urandom_range(13, 15)), 4'($urandom_range(9, 15)),
                  4'($urandom_range(9, 15)));
        random_phase(30);

        drain();
        $display("Sent %0d references over %0d register settings.", sent, settings);
        $display("Checked %0d hits and %0d misses.", hit_count, miss_count);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
